### src/duas_pkg.sv
// ----------------------------------------------------------------------------
// duas_pkg
// Shared types and constants of the dual UART audio serializer.
// ----------------------------------------------------------------------------
package duas_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_AMPLITUDE     = 2'd0;
  localparam logic [1:0] CFG_BIT_SAMPLES   = 2'd1;
  localparam logic [1:0] CFG_FRAME_SAMPLES = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Bit boundaries of a frame: start, eight data bits, stop
  localparam int FRAME_BITS = 10;
  localparam int THR_W      = 12;

  // Reset values of the configuration registers
  localparam logic [14:0] AMPLITUDE_RST     = 15'd24576;
  localparam logic [7:0]  BIT_SAMPLES_RST   = 8'd8;
  localparam logic [15:0] FRAME_SAMPLES_RST = 16'd128;

  // One classified item handed from the front end to the back end
  typedef struct packed {
    logic       is_tick;
    logic       chan;
    logic [7:0] data;
  } item_t;

  // Derived configuration seen by the back end
  typedef struct packed {
    logic [14:0]                       amplitude;
    logic [FRAME_BITS-1:0][THR_W-1:0]  thr;        // thr[j] = (j+1) * bit length
    logic [15:0]                       flen;       // frame length in samples
  } cfg_t;

endpackage

### src/duas_in_if.sv
// ----------------------------------------------------------------------------
// duas_in_if
// Input channel: push or tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface duas_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       channel;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output channel, output data_byte,
                  input ready);
  modport sink   (input valid, input mode, input channel, input data_byte,
                  output ready);
endinterface

### src/duas_out_if.sv
// ----------------------------------------------------------------------------
// duas_out_if
// Result channel: stereo samples and push status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface duas_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               is_sample;
  logic               accepted;

  modport source (output valid, output left_sample, output right_sample,
                  output is_sample, output accepted, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input is_sample, input accepted, output ready);
endinterface

### src/duas_cfg.sv
// ----------------------------------------------------------------------------
// duas_cfg
// Configuration registers with precomputed bit boundaries and frame length.
// ----------------------------------------------------------------------------
module duas_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [duas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [duas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output duas_pkg::cfg_t                 cfg
);

  logic [14:0] amp_r, amp_nxt;
  logic [15:0] frame_r, frame_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [duas_pkg::FRAME_BITS-1:0][duas_pkg::THR_W-1:0] thr_r, thr_nxt, thr_new;
  logic [7:0]  bl_eff;
  logic [15:0] ten_bl;

  always_comb begin
    // zero bit length counts as one
    bl_eff = (cfg_wdata[7:0] == 8'd0) ? 8'd1 : cfg_wdata[7:0];
    for (int j = 0; j < duas_pkg::FRAME_BITS; j++) begin
      thr_new[j] = duas_pkg::THR_W'(j + 1) * {4'b0, bl_eff};
    end
    ten_bl = {4'b0, thr_new[duas_pkg::FRAME_BITS-1]};

    amp_nxt   = amp_r;
    frame_nxt = frame_r;
    flen_nxt  = flen_r;
    thr_nxt   = thr_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        duas_pkg::CFG_AMPLITUDE: begin
          amp_nxt = cfg_wdata[14:0];
        end
        duas_pkg::CFG_BIT_SAMPLES: begin
          thr_nxt  = thr_new;
          flen_nxt = (ten_bl > frame_r) ? ten_bl : frame_r;
        end
        duas_pkg::CFG_FRAME_SAMPLES: begin
          frame_nxt = cfg_wdata;
          flen_nxt  = ({4'b0, thr_r[duas_pkg::FRAME_BITS-1]} > cfg_wdata) ?
                      {4'b0, thr_r[duas_pkg::FRAME_BITS-1]} : cfg_wdata;
        end
        default: begin
          // unused index: ignore
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= duas_pkg::AMPLITUDE_RST;
      frame_r <= duas_pkg::FRAME_SAMPLES_RST;
      flen_r  <= duas_pkg::FRAME_SAMPLES_RST;
      for (int j = 0; j < duas_pkg::FRAME_BITS; j++) begin
        thr_r[j] <= duas_pkg::THR_W'(j + 1) * {4'b0, duas_pkg::BIT_SAMPLES_RST};
      end
    end else begin
      amp_r   <= amp_nxt;
      frame_r <= frame_nxt;
      flen_r  <= flen_nxt;
      thr_r   <= thr_nxt;
    end
  end

  assign cfg.amplitude = amp_r;
  assign cfg.thr       = thr_r;
  assign cfg.flen      = flen_r;

endmodule

### src/duas_front.sv
// ----------------------------------------------------------------------------
// duas_front
// Accept input items, classify them, and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module duas_front (
  input  logic              clk,
  input  logic              rst_n,
  duas_in_if.sink           in_if,
  output logic              q_valid,
  output duas_pkg::item_t   q_item,
  input  logic              q_pop
);

  duas_pkg::item_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  duas_pkg::item_t item_in;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_pop && (cnt_r != 2'd0);

  always_comb begin
    item_in.is_tick = in_if.mode;
    item_in.chan    = in_if.channel;
    item_in.data    = in_if.data_byte;

    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

endmodule

### src/duas_back.sv
// ----------------------------------------------------------------------------
// duas_back
// Byte rings, frame sequencing and the registered result stage.
// ----------------------------------------------------------------------------
module duas_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  duas_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  duas_pkg::item_t   q_item,
  output logic              q_pop,
  duas_out_if.source        out_if
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

  logic [7:0] ring_l [RING_DEPTH];
  logic [7:0] ring_r [RING_DEPTH];
  logic [7:0] rd_l_r, rd_r_r;

  logic [PW-1:0] head_l_r, head_l_nxt, tail_l_r, tail_l_nxt;
  logic [PW-1:0] head_r_r, head_r_nxt, tail_r_r, tail_r_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [1:0]    act_r, act_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic signed [15:0] left_r, left_nxt, right_r, right_nxt;
  logic               is_smp_r, is_smp_nxt, acc_r, acc_nxt;

  logic          fire;
  logic          we_l, we_r;
  logic [PW-1:0] tail_sel, head_sel, tail_inc;
  logic          full;
  logic          ne_l, ne_r;
  logic [duas_pkg::FRAME_BITS-1:0] ge;
  logic [7:0]    onehot;
  logic          bit_l, bit_r;
  logic          frame_end;
  logic signed [15:0] amp_p, amp_n;

  function automatic logic [PW-1:0] inc_idx(input logic [PW-1:0] p);
    inc_idx = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  // advance only when the result register is free or being drained
  assign fire  = q_valid && (!ovalid_r || out_if.ready);
  assign q_pop = fire;

  always_comb begin
    ne_l = (head_l_r != tail_l_r);
    ne_r = (head_r_r != tail_r_r);

    tail_sel = q_item.chan ? tail_r_r : tail_l_r;
    head_sel = q_item.chan ? head_r_r : head_l_r;
    tail_inc = inc_idx(tail_sel);
    full     = (tail_inc == head_sel);

    we_l = fire && !q_item.is_tick && !q_item.chan && !full;
    we_r = fire && !q_item.is_tick &&  q_item.chan && !full;

    // bit boundaries passed: ge[j] means position is in bit j+1 or later
    for (int j = 0; j < duas_pkg::FRAME_BITS; j++) begin
      ge[j] = (pos_r >= {{(16 - duas_pkg::THR_W){1'b0}}, cfg.thr[j]});
    end
    onehot = ge[7:0] & ~ge[8:1];
    bit_l  = |(rd_l_r & onehot);
    bit_r  = |(rd_r_r & onehot);

    amp_p = $signed({1'b0, cfg.amplitude});
    amp_n = -amp_p;

    act_nxt   = (pos_r == 16'd0) ? {ne_r, ne_l} : act_r;
    frame_end = ({1'b0, pos_r} + 17'd1) >= {1'b0, cfg.flen};

    head_l_nxt = head_l_r;
    head_r_nxt = head_r_r;
    tail_l_nxt = we_l ? tail_inc : tail_l_r;
    tail_r_nxt = we_r ? tail_inc : tail_r_r;
    pos_nxt    = pos_r;

    ovalid_nxt = fire ? 1'b1 : (ovalid_r && !out_if.ready);
    left_nxt   = left_r;
    right_nxt  = right_r;
    is_smp_nxt = is_smp_r;
    acc_nxt    = acc_r;

    if (fire) begin
      if (q_item.is_tick) begin
        is_smp_nxt = 1'b1;
        acc_nxt    = 1'b1;
        priority if (!ge[0])  left_nxt = amp_p;
        else if (!ge[8])      left_nxt = bit_l ? amp_n : amp_p;
        else if (!ge[9])      left_nxt = amp_n;
        else                  left_nxt = 16'sd0;
        priority if (!ge[0])  right_nxt = amp_p;
        else if (!ge[8])      right_nxt = bit_r ? amp_n : amp_p;
        else if (!ge[9])      right_nxt = amp_n;
        else                  right_nxt = 16'sd0;
        if (!act_nxt[0]) left_nxt  = 16'sd0;
        if (!act_nxt[1]) right_nxt = 16'sd0;
        if (frame_end) begin
          pos_nxt = 16'd0;
          if (act_nxt[0] && ne_l) head_l_nxt = inc_idx(head_l_r);
          if (act_nxt[1] && ne_r) head_r_nxt = inc_idx(head_r_r);
        end else begin
          pos_nxt = pos_r + 16'd1;
        end
      end else begin
        is_smp_nxt = 1'b0;
        acc_nxt    = !full;
        left_nxt   = 16'sd0;
        right_nxt  = 16'sd0;
      end
    end
  end

  // head entry is read every cycle; it is stable for a whole active frame
  always_ff @(posedge clk) begin
    if (we_l) begin
      ring_l[tail_l_r] <= q_item.data;
    end
    rd_l_r <= ring_l[head_l_r];
  end

  always_ff @(posedge clk) begin
    if (we_r) begin
      ring_r[tail_r_r] <= q_item.data;
    end
    rd_r_r <= ring_r[head_r_r];
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    is_smp_r <= is_smp_nxt;
    acc_r    <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_l_r <= '0;
      tail_l_r <= '0;
      head_r_r <= '0;
      tail_r_r <= '0;
      pos_r    <= 16'd0;
      act_r    <= 2'b00;
      ovalid_r <= 1'b0;
    end else begin
      head_l_r <= head_l_nxt;
      tail_l_r <= tail_l_nxt;
      head_r_r <= head_r_nxt;
      tail_r_r <= tail_r_nxt;
      pos_r    <= pos_nxt;
      if (fire && q_item.is_tick) begin
        act_r <= act_nxt;
      end
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_if.valid        = ovalid_r;
  assign out_if.left_sample  = left_r;
  assign out_if.right_sample = right_r;
  assign out_if.is_sample    = is_smp_r;
  assign out_if.accepted     = acc_r;

endmodule

### src/dual_uart_audio_serializer.sv
// ----------------------------------------------------------------------------
// dual_uart_audio_serializer
// Two byte queues sent as inverted 8N1 frames on a stereo sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries items: mode 0 pushes data_byte into the left or right ring
//   (channel 0 or 1), mode 1 is one sample tick. Every item yields exactly
//   one result on out_if: a push reports accepted (0 when the ring was full),
//   a tick carries the left and right Q1.15 samples with is_sample set.
//   Each ring holds up to RING_DEPTH-1 bytes.
//   Throughput is one item per clock while out_if.ready is high. An accepted
//   item is written into the queue, then moved into the result register,
//   which out_if shows; a low out_if.ready can hold it at either step.
//   A two-entry queue splits the accepting front end from the back end that
//   owns the rings; when out_if.ready is low the result register holds, the
//   queue fills, and in_if.ready drops after at most two more items.
//   The cfg port (cfg_we, cfg_idx, cfg_wdata) writes amplitude, bit_samples
//   and frame_samples; write only while no item is in flight. Bit boundaries
//   and the frame length are recomputed at the write edge.
//   Reset (rst_n low, synchronous) empties both rings, restarts the frame
//   position and restores the default register values; ring contents are
//   not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module dual_uart_audio_serializer #(
  parameter int RING_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  duas_in_if.sink                         in_if,
  duas_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [duas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [duas_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  duas_pkg::cfg_t  cfg;
  duas_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // register file: holds amplitude, bit boundaries and frame length
  duas_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // front end: accept and classify items, queue them
  duas_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back end: rings, frame sequencing, result register
  duas_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
